// ===== hdl/text_console_writer_macros.svh =====
// assertion macros for the text console writer
// simulation builds get the checks, synthesis builds get empty bodies
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TCW_ASSERT_SAME(label, ante, cons, msg)
`define TCW_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hdl/tcw_pkg.sv =====
package tcw_pkg;

  // default buffer geometry
  localparam int unsigned MAX_COLS_DEF = 128;
  localparam int unsigned MAX_ROWS_DEF = 32;

  // configuration register defaults
  localparam int unsigned COLS_RESET = 80;
  localparam int unsigned ROWS_RESET = 25;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS = 1'b1;

  // cell and character constants
  localparam logic [15:0] BLANK_CELL   = 16'h0F20;
  localparam logic [7:0]  ATTR_BYTE    = 8'h0F;
  localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [7:0]  CH_BACKSPACE = 8'h08;

  typedef enum logic [1:0] {
    OP_PUT       = 2'd0,
    OP_BACKSPACE = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_READ      = 2'd3
  } op_e;

  // sequencer step counter and step labels
  localparam int unsigned UPC_W = 5;
  typedef logic [UPC_W-1:0] step_t;

  localparam step_t S_INIT     = 5'd0;
  localparam step_t S_IDLE     = 5'd1;
  localparam step_t S_PUTC     = 5'd2;
  localparam step_t S_NEWLINE  = 5'd3;
  localparam step_t S_PCHK     = 5'd4;
  localparam step_t S_SC_TEST  = 5'd5;
  localparam step_t S_SC_RD    = 5'd6;
  localparam step_t S_SC_WR    = 5'd7;
  localparam step_t S_SB_SET   = 5'd8;
  localparam step_t S_SB_WR    = 5'd9;
  localparam step_t S_FIN      = 5'd10;
  localparam step_t S_BS_TEST  = 5'd11;
  localparam step_t S_BS_DEC   = 5'd12;
  localparam step_t S_BS_ROW   = 5'd13;
  localparam step_t S_BS_PREV  = 5'd14;
  localparam step_t S_BS_WR    = 5'd15;
  localparam step_t S_CL_SET   = 5'd16;
  localparam step_t S_CL_WR    = 5'd17;
  localparam step_t S_CL_END   = 5'd18;
  localparam step_t S_RD_ADDR  = 5'd19;
  localparam step_t S_RD_DATA  = 5'd20;

  // next step selection
  typedef enum logic [2:0] {
    NXT_SEQ      = 3'd0,
    NXT_GOTO     = 3'd1,
    NXT_IF       = 3'd2,
    NXT_WAIT     = 3'd3,
    NXT_DISPATCH = 3'd4
  } nxt_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_TRUE     = 3'd0,
    COND_LAST     = 3'd1,
    COND_ROW_OVF  = 3'd2,
    COND_ONE_ROW  = 3'd3,
    COND_COL_ZERO = 3'd4,
    COND_ROW_ZERO = 3'd5,
    COND_OUT_FREE = 3'd6
  } cond_e;

  typedef enum logic [1:0] {
    ADDR_CURSOR    = 2'd0,
    ADDR_WALK      = 2'd1,
    ADDR_WALK_NEXT = 2'd2,
    ADDR_READ      = 2'd3
  } asel_e;

  typedef enum logic [1:0] {
    WD_BLANK = 2'd0,
    WD_CHAR  = 2'd1,
    WD_RDATA = 2'd2
  } wsel_e;

  typedef enum logic [1:0] {
    WALK_HOLD   = 2'd0,
    WALK_ZERO   = 2'd1,
    WALK_ADV    = 2'd2,
    WALK_BOTTOM = 2'd3
  } walk_e;

  // walk bounds: whole buffer, active area, active area less its last row
  typedef enum logic [1:0] {
    LIM_FULL   = 2'd0,
    LIM_ACTIVE = 2'd1,
    LIM_SCROLL = 2'd2
  } lim_e;

  typedef enum logic [2:0] {
    CUR_HOLD     = 3'd0,
    CUR_ADV      = 3'd1,
    CUR_NEWLINE  = 3'd2,
    CUR_CLAMP    = 3'd3,
    CUR_DEC      = 3'd4,
    CUR_PREV_ROW = 3'd5,
    CUR_HOME     = 3'd6
  } curop_e;

  // one control word
  typedef struct packed {
    nxt_e   nxt;
    cond_e  cond;
    logic   inv;
    step_t  target;
    logic   take;
    logic   ram_re;
    logic   ram_we;
    asel_e  asel;
    wsel_e  wsel;
    walk_e  wop;
    lim_e   lim;
    curop_e cop;
    logic   set_scr;
    logic   load_data;
    logic   load_out;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    nxt:       NXT_SEQ,
    cond:      COND_TRUE,
    inv:       1'b0,
    target:    S_INIT,
    take:      1'b0,
    ram_re:    1'b0,
    ram_we:    1'b0,
    asel:      ADDR_CURSOR,
    wsel:      WD_BLANK,
    wop:       WALK_HOLD,
    lim:       LIM_ACTIVE,
    cop:       CUR_HOLD,
    set_scr:   1'b0,
    load_data: 1'b0,
    load_out:  1'b0
  };

  // control store
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (step)
      // clearing pass over the whole buffer after reset
      S_INIT: begin
        w.ram_we = 1'b1;
        w.asel   = ADDR_WALK;
        w.wsel   = WD_BLANK;
        w.wop    = WALK_ADV;
        w.lim    = LIM_FULL;
        w.nxt    = NXT_IF;
        w.cond   = COND_LAST;
        w.inv    = 1'b1;
        w.target = S_INIT;
      end
      S_IDLE: begin
        w.take = 1'b1;
        w.nxt  = NXT_DISPATCH;
      end
      // put a printable character
      S_PUTC: begin
        w.ram_we = 1'b1;
        w.asel   = ADDR_CURSOR;
        w.wsel   = WD_CHAR;
        w.cop    = CUR_ADV;
        w.nxt    = NXT_GOTO;
        w.target = S_PCHK;
      end
      S_NEWLINE: begin
        w.cop = CUR_NEWLINE;
      end
      // scroll check
      S_PCHK: begin
        w.wop    = WALK_ZERO;
        w.nxt    = NXT_IF;
        w.cond   = COND_ROW_OVF;
        w.inv    = 1'b1;
        w.target = S_FIN;
      end
      S_SC_TEST: begin
        w.nxt    = NXT_IF;
        w.cond   = COND_ONE_ROW;
        w.target = S_SB_SET;
      end
      // copy one cell up a row
      S_SC_RD: begin
        w.ram_re = 1'b1;
        w.asel   = ADDR_WALK_NEXT;
      end
      S_SC_WR: begin
        w.ram_we = 1'b1;
        w.asel   = ADDR_WALK;
        w.wsel   = WD_RDATA;
        w.wop    = WALK_ADV;
        w.lim    = LIM_SCROLL;
        w.nxt    = NXT_IF;
        w.cond   = COND_LAST;
        w.inv    = 1'b1;
        w.target = S_SC_RD;
      end
      // blank the bottom row
      S_SB_SET: begin
        w.wop     = WALK_BOTTOM;
        w.cop     = CUR_CLAMP;
        w.set_scr = 1'b1;
      end
      S_SB_WR: begin
        w.ram_we = 1'b1;
        w.asel   = ADDR_WALK;
        w.wsel   = WD_BLANK;
        w.wop    = WALK_ADV;
        w.lim    = LIM_ACTIVE;
        w.nxt    = NXT_IF;
        w.cond   = COND_LAST;
        w.inv    = 1'b1;
        w.target = S_SB_WR;
      end
      // hand the result to the output register
      S_FIN: begin
        w.load_out = 1'b1;
        w.nxt      = NXT_WAIT;
        w.cond     = COND_OUT_FREE;
        w.target   = S_IDLE;
      end
      // backspace
      S_BS_TEST: begin
        w.nxt    = NXT_IF;
        w.cond   = COND_COL_ZERO;
        w.target = S_BS_ROW;
      end
      S_BS_DEC: begin
        w.cop    = CUR_DEC;
        w.nxt    = NXT_GOTO;
        w.target = S_BS_WR;
      end
      S_BS_ROW: begin
        w.nxt    = NXT_IF;
        w.cond   = COND_ROW_ZERO;
        w.target = S_FIN;
      end
      S_BS_PREV: begin
        w.cop = CUR_PREV_ROW;
      end
      S_BS_WR: begin
        w.ram_we = 1'b1;
        w.asel   = ADDR_CURSOR;
        w.wsel   = WD_BLANK;
        w.nxt    = NXT_GOTO;
        w.target = S_FIN;
      end
      // clear the active area
      S_CL_SET: begin
        w.wop = WALK_ZERO;
        w.cop = CUR_HOME;
      end
      S_CL_WR: begin
        w.ram_we = 1'b1;
        w.asel   = ADDR_WALK;
        w.wsel   = WD_BLANK;
        w.wop    = WALK_ADV;
        w.lim    = LIM_ACTIVE;
        w.nxt    = NXT_IF;
        w.cond   = COND_LAST;
        w.inv    = 1'b1;
        w.target = S_CL_WR;
      end
      S_CL_END: begin
        w.nxt    = NXT_GOTO;
        w.target = S_FIN;
      end
      // read one cell
      S_RD_ADDR: begin
        w.ram_re = 1'b1;
        w.asel   = ADDR_READ;
      end
      S_RD_DATA: begin
        w.load_data = 1'b1;
        w.nxt       = NXT_GOTO;
        w.target    = S_FIN;
      end
      default: begin
        w.nxt    = NXT_GOTO;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

  // entry step for a new request
  function automatic step_t entry(input op_e op, input logic [7:0] ch);
    step_t s;
    s = S_IDLE;
    unique case (op)
      OP_PUT: begin
        if (ch == CH_NEWLINE) begin
          s = S_NEWLINE;
        end else if (ch == CH_BACKSPACE) begin
          s = S_PCHK;
        end else begin
          s = S_PUTC;
        end
      end
      OP_BACKSPACE: s = S_BS_TEST;
      OP_CLEAR:     s = S_CL_SET;
      OP_READ:      s = S_RD_ADDR;
      default:      s = S_IDLE;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/tcw_ram.sv =====
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    addr_i,
  input  logic             we_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/text_console_writer.sv =====
// channel | dir | handshake              | payload
// in      | in  | in_valid_i / in_ready_o | opcode_i char_code_i read_col_i read_row_i
// out     | out | out_valid_o / out_ready_i | cursor_col_out_o cursor_row_out_o
//         |     |                         |   cell_data_o scrolled_o
// cfg     | in  | cfg_we_i (no wait)      | cfg_index_i cfg_wdata_i
//
// one request at a time
// clear and scroll walk the single-port cell buffer, one cell access per cycle
// after reset a clearing pass writes all MAX_COLS*MAX_ROWS cells with in_ready_o low;
// configuration writes are taken throughout
// a new request is taken while a result waits; the sequencer holds in its last step
// until the output register is free
`include "text_console_writer_macros.svh"

module text_console_writer #(
  parameter int unsigned MAX_COLS = tcw_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // requests
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     opcode_i,
  input  logic [7:0]                     char_code_i,
  input  logic [6:0]                     read_col_i,
  input  logic [4:0]                     read_row_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [6:0]                     cursor_col_out_o,
  output logic [4:0]                     cursor_row_out_o,
  output logic [15:0]                    cell_data_o,
  output logic                           scrolled_o
);

  import tcw_pkg::*;

  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ACW   = $clog2(MAX_COLS + 1);
  localparam int unsigned ARW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RST_COLS = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;
  localparam int unsigned RST_ROWS = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;

  // sequencer
  step_t upc_q, upc_d;
  ctrl_t ctl;
  logic  in_accept;
  logic  cond_flag, cond_ok;

  // configuration, held already clamped
  logic [ACW-1:0] cols_act_q, cols_act_d;
  logic [ARW-1:0] rows_act_q, rows_act_d;

  // request fields used after dispatch
  logic [7:0] char_q;
  logic [6:0] rd_col_q;
  logic [4:0] rd_row_q;
  logic       rd_in_range;

  // cursor and buffer walk
  logic [CW-1:0]  cur_col_q, cur_col_d;
  logic [ARW-1:0] cur_row_q, cur_row_d;
  logic [CW-1:0]  wc_q, wc_d;
  logic [RW-1:0]  wr_q, wr_d;
  logic [ACW-1:0] clim;
  logic [ARW-1:0] rlim;
  logic           walk_col_end, walk_last;

  // buffer port
  logic [RW-1:0]  row_sel;
  logic [CW-1:0]  col_sel;
  logic [AW-1:0]  ram_addr;
  logic [15:0]    ram_wdata, ram_rdata;

  // result under construction and output register
  logic        scr_q;
  logic [15:0] data_q;
  logic        out_free, out_load;
  logic        out_valid_q;
  logic [6:0]  out_col_q;
  logic [4:0]  out_row_q;
  logic [15:0] out_data_q;
  logic        out_scr_q;

  assign ctl        = ucode(upc_q);
  assign in_ready_o = ctl.take;
  assign in_accept  = in_valid_i & ctl.take;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign out_load   = ctl.load_out & out_free;

  // condition select
  always_comb begin
    case (ctl.cond)
      COND_TRUE:     cond_flag = 1'b1;
      COND_LAST:     cond_flag = walk_last;
      COND_ROW_OVF:  cond_flag = (cur_row_q >= rows_act_q);
      COND_ONE_ROW:  cond_flag = (rows_act_q == ARW'(1));
      COND_COL_ZERO: cond_flag = (cur_col_q == '0);
      COND_ROW_ZERO: cond_flag = (cur_row_q == '0);
      COND_OUT_FREE: cond_flag = out_free;
      default:       cond_flag = 1'b0;
    endcase
  end

  assign cond_ok = cond_flag ^ ctl.inv;

  // next step
  always_comb begin
    unique case (ctl.nxt)
      NXT_SEQ:      upc_d = upc_q + step_t'(1);
      NXT_GOTO:     upc_d = ctl.target;
      NXT_IF:       upc_d = cond_ok ? ctl.target : upc_q + step_t'(1);
      NXT_WAIT:     upc_d = cond_ok ? ctl.target : upc_q;
      NXT_DISPATCH: upc_d = in_accept ? entry(op_e'(opcode_i), char_code_i) : upc_q;
      default:      upc_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_INIT;
    end else begin
      upc_q <= upc_d;
    end
  end

  // configuration writes, clamped to the buffer geometry
  always_comb begin
    cols_act_d = cols_act_q;
    rows_act_d = rows_act_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SCREEN_COLS: begin
          if (cfg_wdata_i == '0) begin
            cols_act_d = ACW'(1);
          end else if (32'(cfg_wdata_i) > MAX_COLS) begin
            cols_act_d = ACW'(MAX_COLS);
          end else begin
            cols_act_d = ACW'(cfg_wdata_i);
          end
        end
        REG_SCREEN_ROWS: begin
          if (cfg_wdata_i[5:0] == '0) begin
            rows_act_d = ARW'(1);
          end else if (32'(cfg_wdata_i[5:0]) > MAX_ROWS) begin
            rows_act_d = ARW'(MAX_ROWS);
          end else begin
            rows_act_d = ARW'(cfg_wdata_i[5:0]);
          end
        end
        default: begin
          cols_act_d = cols_act_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_act_q <= ACW'(RST_COLS);
      rows_act_q <= ARW'(RST_ROWS);
    end else begin
      cols_act_q <= cols_act_d;
      rows_act_q <= rows_act_d;
    end
  end

  // request fields
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q   <= char_code_i;
      rd_col_q <= read_col_i;
      rd_row_q <= read_row_i;
    end
  end

  assign rd_in_range = (32'(rd_row_q) < MAX_ROWS) && (32'(rd_col_q) < MAX_COLS);

  // walk bounds
  always_comb begin
    clim = (ctl.lim == LIM_FULL) ? ACW'(MAX_COLS) : cols_act_q;
    case (ctl.lim)
      LIM_FULL:   rlim = ARW'(MAX_ROWS);
      LIM_SCROLL: rlim = rows_act_q - ARW'(1);
      default:    rlim = rows_act_q;
    endcase
  end

  assign walk_col_end = (ACW'(wc_q) == clim - ACW'(1));
  assign walk_last    = walk_col_end && (ARW'(wr_q) == rlim - ARW'(1));

  // walk counters, row by row over the selected area
  always_comb begin
    wc_d = wc_q;
    wr_d = wr_q;
    unique case (ctl.wop)
      WALK_HOLD: begin
        wc_d = wc_q;
      end
      WALK_ZERO: begin
        wc_d = '0;
        wr_d = '0;
      end
      WALK_ADV: begin
        if (walk_col_end) begin
          wc_d = '0;
          wr_d = wr_q + RW'(1);
        end else begin
          wc_d = wc_q + CW'(1);
        end
      end
      WALK_BOTTOM: begin
        wc_d = '0;
        wr_d = RW'(rows_act_q - ARW'(1));
      end
      default: begin
        wc_d = wc_q;
      end
    endcase
  end

  // cursor updates
  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    unique case (ctl.cop)
      CUR_HOLD: begin
        cur_col_d = cur_col_q;
      end
      CUR_ADV: begin
        if (ACW'(cur_col_q) + ACW'(1) >= cols_act_q) begin
          cur_col_d = '0;
          cur_row_d = cur_row_q + ARW'(1);
        end else begin
          cur_col_d = cur_col_q + CW'(1);
        end
      end
      CUR_NEWLINE: begin
        cur_col_d = '0;
        cur_row_d = cur_row_q + ARW'(1);
      end
      CUR_CLAMP: begin
        cur_row_d = rows_act_q - ARW'(1);
      end
      CUR_DEC: begin
        cur_col_d = cur_col_q - CW'(1);
      end
      CUR_PREV_ROW: begin
        cur_row_d = cur_row_q - ARW'(1);
        cur_col_d = CW'(cols_act_q - ACW'(1));
      end
      CUR_HOME: begin
        cur_col_d = '0;
        cur_row_d = '0;
      end
      default: begin
        cur_col_d = cur_col_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      wc_q      <= '0;
      wr_q      <= '0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      wc_q      <= wc_d;
      wr_q      <= wr_d;
    end
  end

  // buffer address and write data
  always_comb begin
    unique case (ctl.asel)
      ADDR_CURSOR: begin
        row_sel = RW'(cur_row_q);
        col_sel = cur_col_q;
      end
      ADDR_WALK: begin
        row_sel = wr_q;
        col_sel = wc_q;
      end
      ADDR_WALK_NEXT: begin
        row_sel = wr_q + RW'(1);
        col_sel = wc_q;
      end
      ADDR_READ: begin
        row_sel = RW'(rd_row_q);
        col_sel = CW'(rd_col_q);
      end
      default: begin
        row_sel = wr_q;
        col_sel = wc_q;
      end
    endcase
  end

  assign ram_addr = AW'(row_sel) * AW'(MAX_COLS) + AW'(col_sel);

  always_comb begin
    case (ctl.wsel)
      WD_CHAR:  ram_wdata = {ATTR_BYTE, char_q};
      WD_RDATA: ram_wdata = ram_rdata;
      default:  ram_wdata = BLANK_CELL;
    endcase
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_cells (
    .clk_i  (clk_i),
    .addr_i (ram_addr),
    .we_i   (ctl.ram_we),
    .wdata_i(ram_wdata),
    .re_i   (ctl.ram_re),
    .rdata_o(ram_rdata)
  );

  // result fields, cleared when a request is taken
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      scr_q  <= 1'b0;
      data_q <= '0;
    end else begin
      if (ctl.set_scr) begin
        scr_q <= 1'b1;
      end
      if (ctl.load_data) begin
        data_q <= rd_in_range ? ram_rdata : '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_col_q  <= 7'(cur_col_q);
      out_row_q  <= 5'(cur_row_q);
      out_data_q <= data_q;
      out_scr_q  <= scr_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cursor_col_out_o = out_col_q;
  assign cursor_row_out_o = out_row_q;
  assign cell_data_o      = out_data_q;
  assign scrolled_o       = out_scr_q;

  // checks; the cursor row may pass the buffer briefly before a scroll clamps it
  `TCW_ASSERT_SAME(a_row_in_buffer, upc_q == S_IDLE, 32'(cur_row_q) < MAX_ROWS, "cursor row outside buffer")
  `TCW_ASSERT_SAME(a_col_in_buffer, 1'b1, 32'(cur_col_q) < MAX_COLS, "cursor column outside buffer")
  `TCW_ASSERT_NEXT(a_accept_leaves_idle, in_accept, upc_q != S_IDLE, "request taken but sequencer idle")
  `TCW_ASSERT_NEXT(a_load_returns_idle, out_load, upc_q == S_IDLE, "result loaded without return to idle")
  `TCW_ASSERT_SAME(a_no_write_when_idle, upc_q == S_IDLE, !ctl.ram_we, "buffer written while idle")

endmodule

// ===== dv/text_console_writer_tb.sv =====
module text_console_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int unsigned BUF_COLS     = MAX_COLS_DEF;
  localparam int unsigned BUF_ROWS     = MAX_ROWS_DEF;
  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;

  // one cursor report as the block returns it
  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [15:0] cell_word;
    logic        scrolled;
  } console_report_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_SCREEN_COLS;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            opcode_i    = OP_PUT;
  logic [7:0]            char_code_i = '0;
  logic [6:0]            read_col_i  = '0;
  logic [4:0]            read_row_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [6:0]            cursor_col_out_o;
  logic [4:0]            cursor_row_out_o;
  logic [15:0]           cell_data_o;
  logic                  scrolled_o;

  // shadow copy of the console
  logic [15:0]     shadow_cells [BUF_COLS*BUF_ROWS];
  int unsigned     cur_col;
  int unsigned     cur_row;
  logic [7:0]      cols_reg;
  logic [5:0]      rows_reg;
  console_report_t reports_due [$];

  int          errors         = 0;
  int unsigned cycles         = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;

  text_console_writer i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .char_code_i      (char_code_i),
    .read_col_i       (read_col_i),
    .read_row_i       (read_row_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cursor_col_out_o (cursor_col_out_o),
    .cursor_row_out_o (cursor_row_out_o),
    .cell_data_o      (cell_data_o),
    .scrolled_o       (scrolled_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // geometry in use, registers clamped to the buffer
  function automatic int unsigned active_cols();
    if (cols_reg == 0) return 1;
    if (32'(cols_reg) > BUF_COLS) return BUF_COLS;
    return 32'(cols_reg);
  endfunction

  function automatic int unsigned active_rows();
    if (rows_reg == 0) return 1;
    if (32'(rows_reg) > BUF_ROWS) return BUF_ROWS;
    return 32'(rows_reg);
  endfunction

  // apply one request to the shadow console and return the cursor report
  function automatic console_report_t console_step(input op_e op, input logic [7:0] ch,
                                                   input logic [6:0] rc, input logic [4:0] rr);
    console_report_t rep;
    int unsigned     cols;
    int unsigned     rows;
    cols = active_cols();
    rows = active_rows();
    rep  = '0;
    case (op)
      OP_PUT: begin
        if (ch == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (ch != CH_BACKSPACE) begin
          if (cur_row < BUF_ROWS && cur_col < BUF_COLS)
            shadow_cells[cur_row*BUF_COLS + cur_col] = {ATTR_BYTE, ch};
          cur_col++;
          if (cur_col >= cols) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // past the last row: move the active area up one row
        if (cur_row >= rows) begin
          for (int r = 0; r + 1 < rows; r++)
            for (int c = 0; c < cols; c++)
              shadow_cells[r*BUF_COLS + c] = shadow_cells[(r+1)*BUF_COLS + c];
          for (int c = 0; c < cols; c++)
            shadow_cells[(rows-1)*BUF_COLS + c] = BLANK_CELL;
          cur_row      = rows - 1;
          rep.scrolled = 1'b1;
        end
      end
      OP_BACKSPACE: begin
        if (cur_col > 0) begin
          cur_col--;
          shadow_cells[cur_row*BUF_COLS + cur_col] = BLANK_CELL;
        end else if (cur_row > 0) begin
          cur_row--;
          cur_col = cols - 1;
          shadow_cells[cur_row*BUF_COLS + cur_col] = BLANK_CELL;
        end
      end
      OP_CLEAR: begin
        for (int r = 0; r < rows; r++)
          for (int c = 0; c < cols; c++)
            shadow_cells[r*BUF_COLS + c] = BLANK_CELL;
        cur_col = 0;
        cur_row = 0;
      end
      default: begin
        rep.cell_word = shadow_cells[rr*BUF_COLS + rc];
      end
    endcase
    rep.col = 7'(cur_col);
    rep.row = 5'(cur_row);
    return rep;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // result checking and receiver stalls
  always @(posedge clk_i) begin : result_check
    console_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reports_due.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual col %0d row %0d cell 0x%0h scr %0b",
                 $time, cursor_col_out_o, cursor_row_out_o, cell_data_o, scrolled_o);
      end else begin
        want = reports_due.pop_front();
        check_field("cursor_col", 32'(want.col), 32'(cursor_col_out_o));
        check_field("cursor_row", 32'(want.row), 32'(cursor_row_out_o));
        check_field("cell_data", 32'(want.cell_word), 32'(cell_data_o));
        check_field("scrolled", 32'(want.scrolled), 32'(scrolled_o));
      end
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one request and wait until it is taken
  task automatic send_request(input op_e op, input logic [7:0] ch,
                              input logic [6:0] rc, input logic [4:0] rr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    char_code_i <= ch;
    read_col_i  <= rc;
    read_row_i  <= rr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    reports_due.push_back(console_step(op, ch, rc, rr));
  endtask

  // wait until every report is back and the block has gone idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write both geometry registers on back-to-back cycles
  task automatic set_geometry(input logic [7:0] cols_val, input logic [7:0] rows_val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_SCREEN_COLS;
    cfg_wdata_i <= cols_val;
    @(posedge clk_i);
    cfg_index_i <= REG_SCREEN_ROWS;
    cfg_wdata_i <= rows_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cols_reg  = cols_val;
    rows_reg  = rows_val[5:0];
  endtask

  // reset geometry: extreme characters, newline and reads at the buffer corners
  task automatic test_default_geometry();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(OP_PUT, 8'h41, '0, '0);
    send_request(OP_PUT, 8'hFF, 7'h7F, 5'h1F);
    send_request(OP_PUT, 8'h00, '0, '0);
    send_request(OP_PUT, CH_NEWLINE, '0, '0);
    send_request(OP_READ, 8'hFF, 7'd0, 5'd0);
    send_request(OP_READ, 8'h00, 7'd1, 5'd0);
    send_request(OP_READ, 8'h00, 7'h7F, 5'h1F);
  endtask

  // wrap at the row end, scroll, ignored backspace character, cells outside the area
  task automatic test_wrap_and_scroll();
    settle();
    set_geometry(8'd2, 8'd2);
    send_request(OP_CLEAR, '0, '0, '0);
    send_request(OP_PUT, 8'h61, '0, '0);
    send_request(OP_PUT, 8'h62, '0, '0);
    send_request(OP_PUT, 8'h63, '0, '0);
    send_request(OP_PUT, 8'h64, '0, '0);
    send_request(OP_READ, '0, 7'd0, 5'd0);
    send_request(OP_READ, '0, 7'd2, 5'd0);
    send_request(OP_PUT, CH_BACKSPACE, '0, '0);
    send_request(OP_PUT, CH_NEWLINE, '0, '0);
    send_request(OP_READ, '0, 7'd0, 5'd0);
  endtask

  // backspace across a row boundary and at home
  task automatic test_backspace();
    send_request(OP_BACKSPACE, '0, '0, '0);
    send_request(OP_BACKSPACE, '0, '0, '0);
    send_request(OP_BACKSPACE, '0, '0, '0);
    send_request(OP_PUT, 8'h78, '0, '0);
    send_request(OP_BACKSPACE, '0, '0, '0);
    send_request(OP_CLEAR, '0, '0, '0);
    send_request(OP_BACKSPACE, '0, '0, '0);
  endtask

  // random mix of all operations under one geometry and idling pattern
  task automatic test_random_traffic(input logic [7:0] cols_val, input logic [7:0] rows_val,
                                     input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned newline_pct);
    op_e         op;
    logic [7:0]  ch;
    logic [6:0]  rc;
    logic [4:0]  rr;
    int unsigned pick;
    int unsigned roll;
    settle();
    set_geometry(cols_val, rows_val);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      ch   = 8'($urandom_range(255));
      rc   = 7'($urandom);
      rr   = 5'($urandom);
      if (pick < 60) begin
        op   = OP_PUT;
        roll = $urandom_range(99);
        if (roll < newline_pct)
          ch = CH_NEWLINE;
        else if (roll < newline_pct + 4)
          ch = CH_BACKSPACE;
      end else if (pick < 75) begin
        op = OP_BACKSPACE;
      end else if (pick < 77) begin
        op = OP_CLEAR;
      end else begin
        op = OP_READ;
        // half the reads land inside the active area
        if ($urandom_range(1)) begin
          rc = 7'($urandom_range(active_cols() - 1));
          rr = 5'($urandom_range(active_rows() - 1));
        end
      end
      send_request(op, ch, rc, rr);
    end
  endtask

  // long receiver hold-off so the block fills up and stalls its input
  task automatic test_backpressure();
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 300;
    for (int i = 0; i < 24; i++)
      send_request(OP_PUT, 8'h30 + 8'(i), '0, '0);
  endtask

  initial begin : run_tests
    for (int i = 0; i < BUF_COLS*BUF_ROWS; i++)
      shadow_cells[i] = BLANK_CELL;
    cur_col  = 0;
    cur_row  = 0;
    cols_reg = 8'(COLS_RESET);
    rows_reg = 6'(ROWS_RESET);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_geometry();
    test_wrap_and_scroll();
    test_backspace();
    test_random_traffic(8'd8, 8'd4, 180, 0, 0, 10);
    test_random_traffic(8'd16, 8'd6, 150, 78, 0, 10);
    test_random_traffic(8'd5, 8'd3, 150, 0, 78, 10);
    // zero registers clamp to a single cell
    test_random_traffic(8'd0, 8'd0, 100, 12, 12, 10);
    test_backpressure();
    // full buffer, newline heavy so the bottom row is reached
    test_random_traffic(8'd128, 8'd32, 60, 12, 12, 50);
    // all-ones registers clamp to the full buffer
    test_random_traffic(8'hFF, 8'hFF, 40, 12, 12, 10);
    // shrink while the cursor sits far outside the new area
    test_random_traffic(8'd3, 8'd2, 150, 12, 12, 10);
    settle();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
